>>> rtl/btmf_pkg.sv
// Shared types, constants and command structs of the bridge temperature median filter.
package btmf_pkg;

  localparam int WINDOW_LEN = 5;
  localparam int ADC_BITS   = 10;
  localparam int IDX_W      = $clog2(WINDOW_LEN);
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int DIV_W      = 66;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN_A    = 3'd0;
  localparam logic [2:0] REG_OFFSET_A  = 3'd1;
  localparam logic [2:0] REG_GAIN_B    = 3'd2;
  localparam logic [2:0] REG_OFFSET_B  = 3'd3;
  localparam logic [2:0] REG_RATIO     = 3'd4;
  localparam logic [2:0] REG_INV_VOLT  = 3'd5;
  localparam logic [2:0] REG_R2_R0     = 3'd6;
  localparam logic [2:0] REG_ALPHA_INV = 3'd7;

  typedef struct packed {
    logic [9:0] adc_a;
    logic [9:0] adc_b;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] median_temp;
    logic signed [7:0] newest_temp;
    logic              primed;
    logic              clipped;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic ld_in;
    logic st_v;
    logic st_d;
    logic st_q;
    logic st_r;
    logic div_init;
    logic div_step;
    logic st_t;
    logic st_p;
    logic st_s;
    logic st_ring;
    logic ld_out;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

>>> rtl/btmf_ctrl.sv
// Sequencing state machine of the bridge temperature median filter.
module btmf_ctrl import btmf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_V    = 12'b000000000010,
    S_D    = 12'b000000000100,
    S_Q    = 12'b000000001000,
    S_R    = 12'b000000010000,
    S_DI   = 12'b000000100000,
    S_DIV  = 12'b000001000000,
    S_T    = 12'b000010000000,
    S_P    = 12'b000100000000,
    S_S    = 12'b001000000000,
    S_RING = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_V;
        end
      end
      S_V: begin
        cmd.st_v  = 1'b1;
        state_nxt = S_D;
      end
      S_D: begin
        cmd.st_d  = 1'b1;
        state_nxt = S_Q;
      end
      S_Q: begin
        cmd.st_q  = 1'b1;
        state_nxt = S_R;
      end
      S_R: begin
        cmd.st_r  = 1'b1;
        state_nxt = S_DI;
      end
      S_DI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_T;
      end
      S_T: begin
        cmd.st_t  = 1'b1;
        state_nxt = S_P;
      end
      S_P: begin
        cmd.st_p  = 1'b1;
        state_nxt = S_S;
      end
      S_S: begin
        cmd.st_s  = 1'b1;
        state_nxt = S_RING;
      end
      S_RING: begin
        cmd.st_ring = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output word valid flag.
  always_comb begin
    if (cmd.ld_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/btmf_dp.sv
// Datapath of the bridge temperature median filter: registers, arithmetic, divider and ring.
module btmf_dp import btmf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  in_word_t    in_data,
  input  cmd_t        cmd,
  output status_t     status,
  output out_word_t   out_data
);

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Configuration registers.
  logic [31:0]        gain_a_r, gain_b_r, inv_volt_r, r2_r0_r;
  logic signed [31:0] offset_a_r, offset_b_r, alpha_inv_r;
  logic [16:0]        ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_a_r    <= 32'd65536;
      offset_a_r  <= '0;
      gain_b_r    <= 32'd65536;
      offset_b_r  <= '0;
      ratio_r     <= 17'd32768;
      inv_volt_r  <= 32'd1048576;
      r2_r0_r     <= 32'd65536;
      alpha_inv_r <= 32'sd17022320;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_A:    gain_a_r    <= cfg_wdata;
        REG_OFFSET_A:  offset_a_r  <= $signed(cfg_wdata);
        REG_GAIN_B:    gain_b_r    <= cfg_wdata;
        REG_OFFSET_B:  offset_b_r  <= $signed(cfg_wdata);
        REG_RATIO:     ratio_r     <= cfg_wdata[16:0];
        REG_INV_VOLT:  inv_volt_r  <= cfg_wdata;
        REG_R2_R0:     r2_r0_r     <= cfg_wdata;
        REG_ALPHA_INV: alpha_inv_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Working registers.
  logic [ADC_BITS-1:0]   a_r, b_r;
  logic signed [43:0]    va_r, vb_r;
  logic signed [31:0]    d_r;
  logic signed [33:0]    m_r;
  logic signed [66:0]    num_r;
  logic                  neg_r, bad_r, clip_r;
  logic [DIV_W-1:0]      quo_r;
  logic [32:0]           rem_r, den_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic signed [31:0]    rel_r;
  logic signed [63:0]    p_r;
  logic signed [7:0]     t_r;

  // Combinational arithmetic for each step.
  logic [41:0]         prod_a, prod_b;
  logic signed [43:0]  va_nxt, vb_nxt;
  logic signed [44:0]  diff;
  logic signed [63:0]  prod_q;
  logic signed [34:0]  den_full;
  logic signed [33:0]  mc;
  logic signed [66:0]  num_nxt, num_abs;
  logic [33:0]         trial;
  logic                trial_ge;
  logic signed [66:0]  rn;
  logic signed [67:0]  rel_full;
  logic signed [64:0]  p_adj;
  logic signed [32:0]  p_trunc;

  always_comb begin
    prod_a   = 42'(a_r) * 42'(gain_a_r);
    prod_b   = 42'(b_r) * 42'(gain_b_r);
    va_nxt   = $signed({2'b00, prod_a}) - 44'(offset_a_r);
    vb_nxt   = $signed({2'b00, prod_b}) - 44'(offset_b_r);
    diff     = 45'(va_r) - 45'(vb_r);
    prod_q   = 64'(d_r) * $signed({32'b0, inv_volt_r});
    den_full = 35'sd65536 - 35'(m_r);
    mc       = (m_r < 34'(S32_MIN)) ? 34'(S32_MIN) : m_r;
    num_nxt  = $signed({35'b0, r2_r0_r}) * 67'(mc);
    num_abs  = num_r[66] ? -num_r : num_r;
    trial    = {rem_r, quo_r[DIV_W-1]};
    trial_ge = (trial >= {1'b0, den_r});
    rn       = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    rel_full = 68'(rn) - 68'sd65536;
    p_adj    = p_r[63] ? (65'(p_r) + 65'sh0FFFFFFFF) : 65'(p_r);
    p_trunc  = p_adj[64:32];
  end

  assign status.div_last = (div_cnt_r == DIV_CNT_W'(DIV_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      a_r    <= in_data.adc_a[ADC_BITS-1:0];
      b_r    <= in_data.adc_b[ADC_BITS-1:0];
      clip_r <= 1'b0;
    end
    if (cmd.st_v) begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
    // Difference saturated to 32 bits.
    if (cmd.st_d) begin
      if (diff > 45'(S32_MAX)) begin
        d_r <= S32_MAX; clip_r <= 1'b1;
      end else if (diff < 45'(S32_MIN)) begin
        d_r <= S32_MIN; clip_r <= 1'b1;
      end else begin
        d_r <= diff[31:0];
      end
    end
    if (cmd.st_q) m_r <= $signed({17'b0, ratio_r}) - 34'($signed(prod_q[63:32]));
    if (cmd.st_r) num_r <= num_nxt;
    // Divider setup and non-positive divisor check.
    if (cmd.div_init) begin
      neg_r     <= num_r[66];
      quo_r     <= num_abs[DIV_W-1:0];
      rem_r     <= '0;
      den_r     <= den_full[32:0];
      div_cnt_r <= '0;
      bad_r     <= (den_full <= 35'sd0);
      if (den_full <= 35'sd0 || m_r < 34'(S32_MIN)) clip_r <= 1'b1;
    end
    // One restoring division bit per cycle.
    if (cmd.div_step) begin
      rem_r     <= trial_ge ? 33'(trial - {1'b0, den_r}) : trial[32:0];
      quo_r     <= {quo_r[DIV_W-2:0], trial_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.st_t) begin
      if (rel_full > 68'(S32_MAX)) begin
        rel_r <= S32_MAX; if (!bad_r) clip_r <= 1'b1;
      end else if (rel_full < 68'(S32_MIN)) begin
        rel_r <= S32_MIN; if (!bad_r) clip_r <= 1'b1;
      end else begin
        rel_r <= rel_full[31:0];
      end
    end
    if (cmd.st_p) p_r <= 64'(rel_r) * 64'(alpha_inv_r);
    // Final truncation and byte saturation.
    if (cmd.st_s) begin
      if (bad_r) begin
        t_r <= 8'sd127;
      end else if (p_trunc > 33'sd127) begin
        t_r <= 8'sd127; clip_r <= 1'b1;
      end else if (p_trunc < -33'sd128) begin
        t_r <= -8'sd128; clip_r <= 1'b1;
      end else begin
        t_r <= p_trunc[7:0];
      end
    end
  end

  // Sample ring with write index and fill count.
  logic signed [7:0] ring_r [WINDOW_LEN];
  logic [IDX_W-1:0]  widx_r;
  logic [CNT_W-1:0]  fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) ring_r[i] <= '0;
      widx_r <= '0;
      fill_r <= '0;
    end else if (cmd.st_ring) begin
      ring_r[widx_r] <= t_r;
      widx_r <= (widx_r == IDX_W'(WINDOW_LEN - 1)) ? '0 : widx_r + 1'b1;
      if (fill_r < CNT_W'(WINDOW_LEN)) fill_r <= fill_r + 1'b1;
    end
  end

  // Median by rank: the entry with fewer-than and at-most counts around the middle.
  logic signed [7:0] median;
  logic [CNT_W-1:0]  lt_cnt, le_cnt;

  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      lt_cnt = '0;
      le_cnt = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (ring_r[j] < ring_r[i]) lt_cnt = lt_cnt + 1'b1;
        if (ring_r[j] <= ring_r[i]) le_cnt = le_cnt + 1'b1;
      end
      if (lt_cnt <= CNT_W'(WINDOW_LEN / 2) && le_cnt > CNT_W'(WINDOW_LEN / 2))
        median = ring_r[i];
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_data.median_temp <= median;
      out_data.newest_temp <= t_r;
      out_data.primed      <= (fill_r >= CNT_W'(WINDOW_LEN));
      out_data.clipped     <= clip_r;
    end
  end

endmodule

>>> rtl/bridge_temperature_median_filter.sv
// Top level of the bridge temperature median filter.
// The input channel takes one word with two converter counts (adc_a, adc_b)
// when in_valid is high and in_stall is low. Each word yields exactly one
// result word on the output channel, moved when out_valid is high and
// out_stall is low. The result carries the newest temperature, the median of
// the last five temperatures, a primed flag and a clipped flag.
// A word in work passes ten fixed steps and a restoring divider that forms
// one quotient bit per cycle. A new word is taken in the cycle after the
// previous result is loaded at the earliest, so one word is computed at a
// time. in_stall is high while a word is in work. A stalled result holds in
// the output register; the next word is accepted and computed meanwhile, and
// its result waits until the output register frees.
// Configuration must be written by the user through cfg_we, cfg_index and
// cfg_wdata only while idle; the block itself does not enforce this.
// Synchronous reset restores the register defaults, clears the ring, the write
// index and the fill count, and drops out_valid.
module bridge_temperature_median_filter import btmf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data
);

  cmd_t    cmd;
  status_t status;

  btmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  btmf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  // An accepted word makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting a word");

  // A result appears only at the end of a word in work.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a word in work");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

>>> bench/tb_bridge_temperature_median_filter.sv
// Self-checking testbench for the bridge temperature median filter.
`timescale 1ns / 1ps

import btmf_pkg::*;

// Tracks register settings and the sample ring, predicts each result word
// and checks the words that the block delivers.
class median_temp_tracker;
  longint gain_a, offset_a, gain_b, offset_b;
  longint ratio, inv_volt, r2_r0, alpha_inv;
  byte ring[WINDOW_LEN];
  int wr_slot;
  int filled;
  out_word_t expected_words[$];
  int errors;
  int words_checked;
  int clip_count;

  function new();
    gain_a = 65536;
    offset_a = 0;
    gain_b = 65536;
    offset_b = 0;
    ratio = 32768;
    inv_volt = 1048576;
    r2_r0 = 65536;
    alpha_inv = 17022320;
    foreach (ring[i]) ring[i] = 0;
    wr_slot = 0;
    filled = 0;
    errors = 0;
    words_checked = 0;
    clip_count = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_GAIN_A:    gain_a = longint'({32'b0, v});
      REG_OFFSET_A:  offset_a = longint'(signed'(v));
      REG_GAIN_B:    gain_b = longint'({32'b0, v});
      REG_OFFSET_B:  offset_b = longint'(signed'(v));
      REG_RATIO:     ratio = longint'({47'b0, v[16:0]});
      REG_INV_VOLT:  inv_volt = longint'({32'b0, v});
      REG_R2_R0:     r2_r0 = longint'({32'b0, v});
      REG_ALPHA_INV: alpha_inv = longint'(signed'(v));
      default: ;
    endcase
  endfunction

  // Clamps to the signed 32-bit range and flags saturation.
  function longint clamp32(longint x, inout bit hit);
    if (x > 64'sd2147483647) begin
      hit = 1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      hit = 1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // Converts one pair of counts to a saturated temperature in degrees.
  function int bridge_temp(in_word_t w, output bit clip);
    longint va, vb, d, q, m, den, mc, rn, rel, prod;
    clip = 0;
    va = longint'(w.adc_a) * gain_a - offset_a;
    vb = longint'(w.adc_b) * gain_b - offset_b;
    d = clamp32(va - vb, clip);
    q = (d * inv_volt) >>> 32;
    m = ratio - q;
    den = 64'sd65536 - m;
    if (den <= 0) begin
      clip = 1;
      return 127;
    end
    mc = m;
    if (mc < -64'sd2147483648) begin
      mc = -64'sd2147483648;
      clip = 1;
    end
    rn = (r2_r0 * mc) / den;
    rel = clamp32(rn - 64'sd65536, clip);
    prod = (rel * alpha_inv) / 64'sd4294967296;
    if (prod > 127) begin
      prod = 127;
      clip = 1;
    end
    if (prod < -128) begin
      prod = -128;
      clip = 1;
    end
    return int'(prod);
  endfunction

  // Median of the whole ring, zeros from reset included.
  function byte ring_median();
    byte s[WINDOW_LEN];
    byte v;
    int j;
    s = ring;
    for (int i = 1; i < WINDOW_LEN; i++) begin
      v = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > v) begin
        s[j + 1] = s[j];
        j--;
      end
      s[j + 1] = v;
    end
    return s[WINDOW_LEN / 2];
  endfunction

  // Called for each accepted input word.
  function void note_reading(in_word_t w);
    out_word_t r;
    bit clip;
    int t;
    t = bridge_temp(w, clip);
    ring[wr_slot] = byte'(t);
    wr_slot = (wr_slot + 1) % WINDOW_LEN;
    if (filled < WINDOW_LEN) filled++;
    r.median_temp = ring_median();
    r.newest_temp = t[7:0];
    r.primed = (filled >= WINDOW_LEN);
    r.clipped = clip;
    expected_words.push_back(r);
  endfunction

  // Called for each accepted result word.
  function void check_result(out_word_t got);
    out_word_t exp_w;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
      return;
    end
    exp_w = expected_words.pop_front();
    words_checked++;
    if (exp_w.clipped) clip_count++;
    if (got.median_temp !== exp_w.median_temp) begin
      $display("%0t: median_temp expected %0d actual %0d", $time,
               exp_w.median_temp, got.median_temp);
      errors++;
    end
    if (got.newest_temp !== exp_w.newest_temp) begin
      $display("%0t: newest_temp expected %0d actual %0d", $time,
               exp_w.newest_temp, got.newest_temp);
      errors++;
    end
    if (got.primed !== exp_w.primed) begin
      $display("%0t: primed expected %0b actual %0b", $time, exp_w.primed, got.primed);
      errors++;
    end
    if (got.clipped !== exp_w.clipped) begin
      $display("%0t: clipped expected %0b actual %0b", $time, exp_w.clipped, got.clipped);
      errors++;
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module tb_bridge_temperature_median_filter;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int NUM_PHASES = 7;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_data;

  int snd_idle = 0;
  int rcv_idle = 0;
  int cycles = 0;
  int words_sent = 0;
  median_temp_tracker tracker = new();

  bridge_temperature_median_filter i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Cycle counter with a hard limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < rcv_idle);
  end

  // Every accepted result word is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    tracker.set_reg(idx, v);
  endtask

  // Drives one word, with random sender gaps in front of it.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = w;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    tracker.note_reading(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // Register settings for one phase: defaults, two extreme sets, then
  // random settings that keep most temperatures inside the byte range.
  task automatic configure(int phase);
    logic [31:0] v[8];
    case (phase)
      0: v = '{32'd65536, 32'd0, 32'd65536, 32'd0, 32'd32768, 32'd1048576,
               32'd65536, 32'd17022320};
      1: v = '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'd65536,
               32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF};
      2: v = '{32'd0, 32'h80000000, 32'd0, 32'h80000000, 32'h0001FFFF,
               32'd0, 32'd0, 32'h80000000};
      default: begin
        v[0] = $urandom_range(32768, 131072);
        v[1] = $urandom_range(0, 200000) - 100000;
        v[2] = $urandom_range(32768, 131072);
        v[3] = $urandom_range(0, 200000) - 100000;
        v[4] = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(16384, 49152);
        v[5] = $urandom_range(1 << 18, 1 << 22);
        v[6] = $urandom_range(32768, 131072);
        v[7] = $urandom_range(0, 34044640) - 17022320;
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
  endtask

  // Mostly nearly balanced bridges, which give temperatures in range,
  // with fully random counts mixed in.
  function automatic in_word_t random_word();
    in_word_t w;
    int b;
    w.adc_a = 10'($urandom);
    if ($urandom_range(9) < 7) begin
      b = int'(w.adc_a) + $urandom_range(0, 16) - 8;
      if (b < 0) b = 0;
      if (b > 1023) b = 1023;
      w.adc_b = 10'(b);
    end else begin
      w.adc_b = 10'($urandom);
    end
    return w;
  endfunction

  initial begin
    in_word_t directed[12];
    directed = '{'{10'd0, 10'd0}, '{10'd1023, 10'd1023}, '{10'd1023, 10'd0},
                 '{10'd0, 10'd1023}, '{10'd512, 10'd512}, '{10'd600, 10'd590},
                 '{10'd590, 10'd600}, '{10'd700, 10'd690}, '{10'd1, 10'd0},
                 '{10'd0, 10'd1}, '{10'd341, 10'd682}, '{10'd682, 10'd341}};
    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Idle mix: receiver-heavy stalls, then sender-heavy gaps, then none.
      if (p < 2) begin
        snd_idle = 20;
        rcv_idle = 79;
      end else if (p < 4) begin
        snd_idle = 79;
        rcv_idle = 20;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      configure(p);
      if (p < 2) foreach (directed[i]) send_word(directed[i]);
      for (int n = 0; n < 175; n++) send_word(random_word());
      // The sender holds off here until every result has come back.
      drain();
    end

    $display("Sent %0d words over %0d register settings; %0d results checked,",
             words_sent, NUM_PHASES, tracker.words_checked);
    $display("%0d of them clipped, in %0d cycles.", tracker.clip_count, cycles);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> bridge_temperature_median_filter.f
rtl/btmf_pkg.sv
rtl/btmf_ctrl.sv
rtl/btmf_dp.sv
rtl/bridge_temperature_median_filter.sv
bench/tb_bridge_temperature_median_filter.sv
